/* sv/pdll_pkg.sv */
// Package for the pooled doubly linked list unit.
// Holds sizes, opcodes and sequencer states; no dependencies.
package pdll_pkg;
  localparam int POOL_DEPTH = 64;
  localparam int ELEM_W     = 32;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
  localparam int OPC_W      = 4;
  localparam logic [LINK_W-1:0] NIL       = LINK_W'(POOL_DEPTH);
  localparam logic [LINK_W-1:0] CAP_RESET = LINK_W'(POOL_DEPTH);

  typedef enum logic [OPC_W-1:0] {
    OP_HEAD     = 4'd0,
    OP_TAIL     = 4'd1,
    OP_NEXT     = 4'd2,
    OP_FIND     = 4'd3,
    OP_APPEND   = 4'd4,
    OP_PUSH     = 4'd5,
    OP_AFTER    = 4'd6,
    OP_BEFORE   = 4'd7,
    OP_REMOVE   = 4'd8,
    OP_POP_HEAD = 4'd9,
    OP_POP_TAIL = 4'd10,
    OP_CLEAR    = 4'd11
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_LINK_RD,
    ST_LINK_LAT,
    ST_SCAN,
    ST_INS_WR,
    ST_INS_LINK,
    ST_REM_WR,
    ST_READ_RD,
    ST_READ_LAT,
    ST_RESP,
    ST_OUT
  } state_t;
endpackage

/* sv/pdll_if.sv */
// Channel interfaces for the pooled doubly linked list unit.
// Depends on pdll_pkg.
interface pdll_in_if;
  logic                          valid;
  logic                          ready;
  logic [pdll_pkg::OPC_W-1:0]    opcode;
  logic [pdll_pkg::ELEM_W-1:0]   element;
  logic [pdll_pkg::ELEM_W-1:0]   anchor;
  modport source (output valid, opcode, element, anchor, input ready);
  modport sink   (input valid, opcode, element, anchor, output ready);
endinterface

interface pdll_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [pdll_pkg::ELEM_W-1:0]   value;
  logic [pdll_pkg::IDX_W-1:0]    position;
  logic [pdll_pkg::LINK_W-1:0]   count;
  logic                          is_empty;
  logic                          is_full;
  modport source (output valid, ok, value, position, count, is_empty, is_full, input ready);
  modport sink   (input valid, ok, value, position, count, is_empty, is_full, output ready);
endinterface

interface pdll_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pdll_pkg::LINK_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/pdll_ram.sv */
// Generic single write port RAM with registered read.
// No dependencies.
module pdll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/pooled_doubly_linked_list_unit.sv */
// Pooled doubly linked list: value, next and prev RAMs under one sequencer.
// Head, tail and next read the node via ST_READ_RD and ST_READ_LAT; find walks the list
// from the head node by node; inserts add a scan for the lowest free slot from slot 0.
// One item at a time: the next transfer is taken after the result transfer.
// Reset (synchronous) empties the list and sets capacity to the pool depth; no RAM sweep.
// Depends on pdll_pkg, pdll_if and pdll_ram.
module pooled_doubly_linked_list_unit (
  input  logic            clk,
  input  logic            rst_n,
  pdll_in_if.sink         in_ch,
  pdll_out_if.source      out_ch,
  pdll_cfg_if.sink        cfg_ch
);
  localparam int LW = pdll_pkg::LINK_W;
  localparam int IW = pdll_pkg::IDX_W;
  localparam int EW = pdll_pkg::ELEM_W;
  localparam logic [LW-1:0] NIL = pdll_pkg::NIL;

  pdll_pkg::state_t state_r, state_nxt;
  pdll_pkg::op_t    op_r;
  logic [EW-1:0]    elem_r, anc_r;
  logic [LW-1:0]    cap_r;
  logic [LW-1:0]    head_r, head_nxt, tail_r, tail_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0]    cur_r, cur_nxt, t_r, t_nxt, fs_r, fs_nxt;
  logic [LW-1:0]    n_r, n_nxt, p_r, p_nxt;
  logic             fwd_r, fwd_nxt;
  logic [pdll_pkg::POOL_DEPTH-1:0] used_r, used_nxt;
  logic             ok_r, ok_nxt;
  logic [EW-1:0]    val_r, val_nxt;
  logic [IW-1:0]    pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_empty_r, out_full_r;
  logic [EW-1:0]    out_val_r;
  logic [IW-1:0]    out_pos_r;
  logic [LW-1:0]    out_cnt_r;

  logic [LW-1:0]    eff_cap;
  logic [EW-1:0]    target;
  logic             v_we, n_we, p_we;
  logic [IW-1:0]    v_wa, n_wa, p_wa;
  logic [EW-1:0]    v_wd, v_rd;
  logic [LW-1:0]    n_wd, p_wd, n_rd, p_rd;

  assign eff_cap = (cap_r > NIL) ? NIL : cap_r;
  assign target  = (op_r == pdll_pkg::OP_FIND || op_r == pdll_pkg::OP_REMOVE) ? elem_r : anc_r;

  pdll_ram #(.WIDTH(EW), .DEPTH(pdll_pkg::POOL_DEPTH)) u_val_ram (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(t_r[IW-1:0]), .rdata(v_rd));
  pdll_ram #(.WIDTH(LW), .DEPTH(pdll_pkg::POOL_DEPTH)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(t_r[IW-1:0]), .rdata(n_rd));
  pdll_ram #(.WIDTH(LW), .DEPTH(pdll_pkg::POOL_DEPTH)) u_prev_ram (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(t_r[IW-1:0]), .rdata(p_rd));

  assign in_ch.ready     = (state_r == pdll_pkg::ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.ok       = out_ok_r;
  assign out_ch.value    = out_val_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.count    = out_cnt_r;
  assign out_ch.is_empty = out_empty_r;
  assign out_ch.is_full  = out_full_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = cnt_r;
    cur_nxt = cur_r;
    t_nxt = t_r;
    fs_nxt = fs_r;
    n_nxt = n_r;
    p_nxt = p_r;
    fwd_nxt = fwd_r;
    used_nxt = used_r;
    ok_nxt = ok_r;
    val_nxt = val_r;
    pos_nxt = pos_r;
    out_valid_nxt = out_valid_r;
    v_we = 1'b0;
    n_we = 1'b0;
    p_we = 1'b0;
    v_wa = fs_r[IW-1:0];
    n_wa = fs_r[IW-1:0];
    p_wa = fs_r[IW-1:0];
    v_wd = elem_r;
    n_wd = n_r;
    p_wd = p_r;
    unique case (state_r)
      pdll_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          ok_nxt = 1'b0;
          val_nxt = '0;
          pos_nxt = '0;
          fs_nxt = '0;
          state_nxt = pdll_pkg::ST_DISP;
        end
      end
      pdll_pkg::ST_DISP: begin
        state_nxt = pdll_pkg::ST_RESP;
        case (op_r) inside
          pdll_pkg::OP_HEAD, pdll_pkg::OP_TAIL: begin
            fwd_nxt = (op_r == pdll_pkg::OP_HEAD);
            t_nxt = (op_r == pdll_pkg::OP_HEAD) ? head_r : tail_r;
            if (cnt_r != '0 && t_nxt != NIL) begin
              state_nxt = pdll_pkg::ST_READ_RD;
            end else begin
              cur_nxt = NIL;
            end
          end
          pdll_pkg::OP_NEXT: begin
            t_nxt = cur_r;
            if (cur_r != NIL && used_r[cur_r[IW-1:0]]) begin
              state_nxt = pdll_pkg::ST_READ_RD;
            end else begin
              cur_nxt = NIL;
            end
          end
          pdll_pkg::OP_FIND: begin
            t_nxt = head_r;
            if (head_r != NIL) state_nxt = pdll_pkg::ST_WALK_RD;
          end
          pdll_pkg::OP_APPEND, pdll_pkg::OP_PUSH: begin
            p_nxt = (op_r == pdll_pkg::OP_APPEND) ? tail_r : NIL;
            n_nxt = (op_r == pdll_pkg::OP_APPEND) ? NIL : head_r;
            if (cnt_r < eff_cap) state_nxt = pdll_pkg::ST_SCAN;
          end
          pdll_pkg::OP_AFTER, pdll_pkg::OP_BEFORE: begin
            t_nxt = head_r;
            if (cnt_r < eff_cap && head_r != NIL) state_nxt = pdll_pkg::ST_WALK_RD;
          end
          pdll_pkg::OP_REMOVE: begin
            t_nxt = head_r;
            if (cnt_r != '0 && head_r != NIL) state_nxt = pdll_pkg::ST_WALK_RD;
          end
          pdll_pkg::OP_POP_HEAD, pdll_pkg::OP_POP_TAIL: begin
            t_nxt = (op_r == pdll_pkg::OP_POP_HEAD) ? head_r : tail_r;
            if (cnt_r != '0 && t_nxt != NIL) state_nxt = pdll_pkg::ST_LINK_RD;
          end
          pdll_pkg::OP_CLEAR: begin
            used_nxt = '0;
            head_nxt = NIL;
            tail_nxt = NIL;
            cur_nxt = NIL;
            cnt_nxt = '0;
            ok_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      pdll_pkg::ST_WALK_RD: state_nxt = pdll_pkg::ST_WALK_CHK;
      pdll_pkg::ST_WALK_CHK: begin
        if (v_rd == target) begin
          if (op_r == pdll_pkg::OP_FIND) begin
            ok_nxt = 1'b1;
            pos_nxt = t_r[IW-1:0];
            state_nxt = pdll_pkg::ST_RESP;
          end else begin
            state_nxt = pdll_pkg::ST_LINK_RD;
          end
        end else if (n_rd == NIL) begin
          state_nxt = pdll_pkg::ST_RESP;
        end else begin
          t_nxt = n_rd;
          state_nxt = pdll_pkg::ST_WALK_RD;
        end
      end
      pdll_pkg::ST_LINK_RD: state_nxt = pdll_pkg::ST_LINK_LAT;
      pdll_pkg::ST_LINK_LAT: begin
        case (op_r)
          pdll_pkg::OP_AFTER: begin
            p_nxt = t_r;
            n_nxt = n_rd;
            state_nxt = pdll_pkg::ST_SCAN;
          end
          pdll_pkg::OP_BEFORE: begin
            p_nxt = p_rd;
            n_nxt = t_r;
            state_nxt = pdll_pkg::ST_SCAN;
          end
          default: begin
            p_nxt = p_rd;
            n_nxt = n_rd;
            state_nxt = pdll_pkg::ST_REM_WR;
          end
        endcase
      end
      pdll_pkg::ST_SCAN: begin
        if (fs_r >= eff_cap) begin
          state_nxt = pdll_pkg::ST_RESP;
        end else if (!used_r[fs_r[IW-1:0]]) begin
          state_nxt = pdll_pkg::ST_INS_WR;
        end else begin
          fs_nxt = LW'(fs_r + 1'b1);
        end
      end
      pdll_pkg::ST_INS_WR: begin
        v_we = 1'b1;
        n_we = 1'b1;
        p_we = 1'b1;
        state_nxt = pdll_pkg::ST_INS_LINK;
      end
      pdll_pkg::ST_INS_LINK: begin
        n_wa = p_r[IW-1:0];
        n_wd = fs_r;
        p_wa = n_r[IW-1:0];
        p_wd = fs_r;
        if (p_r != NIL) n_we = 1'b1;
        else head_nxt = fs_r;
        if (n_r != NIL) p_we = 1'b1;
        else tail_nxt = fs_r;
        used_nxt[fs_r[IW-1:0]] = 1'b1;
        cnt_nxt = LW'(cnt_r + 1'b1);
        ok_nxt = 1'b1;
        pos_nxt = fs_r[IW-1:0];
        state_nxt = pdll_pkg::ST_RESP;
      end
      pdll_pkg::ST_REM_WR: begin
        n_wa = p_r[IW-1:0];
        n_wd = n_r;
        p_wa = n_r[IW-1:0];
        p_wd = p_r;
        if (p_r != NIL) n_we = 1'b1;
        else head_nxt = n_r;
        if (n_r != NIL) p_we = 1'b1;
        else tail_nxt = p_r;
        used_nxt[t_r[IW-1:0]] = 1'b0;
        if (cnt_r != '0) cnt_nxt = LW'(cnt_r - 1'b1);
        ok_nxt = 1'b1;
        pos_nxt = t_r[IW-1:0];
        state_nxt = pdll_pkg::ST_RESP;
      end
      pdll_pkg::ST_READ_RD: state_nxt = pdll_pkg::ST_READ_LAT;
      pdll_pkg::ST_READ_LAT: begin
        ok_nxt = 1'b1;
        val_nxt = v_rd;
        pos_nxt = t_r[IW-1:0];
        cur_nxt = fwd_r ? n_rd : p_rd;
        state_nxt = pdll_pkg::ST_RESP;
      end
      pdll_pkg::ST_RESP: begin
        out_valid_nxt = 1'b1;
        state_nxt = pdll_pkg::ST_OUT;
      end
      pdll_pkg::ST_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt = pdll_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pdll_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdll_pkg::ST_IDLE;
      head_r <= NIL;
      tail_r <= NIL;
      cnt_r <= '0;
      cur_r <= NIL;
      fwd_r <= 1'b1;
      used_r <= '0;
      cap_r <= pdll_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r <= cnt_nxt;
      cur_r <= cur_nxt;
      fwd_r <= fwd_nxt;
      used_r <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) cap_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
    fs_r <= fs_nxt;
    n_r <= n_nxt;
    p_r <= p_nxt;
    ok_r <= ok_nxt;
    val_r <= val_nxt;
    pos_r <= pos_nxt;
    if (state_r == pdll_pkg::ST_IDLE && in_ch.valid) begin
      op_r <= pdll_pkg::op_t'(in_ch.opcode);
      elem_r <= in_ch.element;
      anc_r <= in_ch.anchor;
    end
    if (state_r == pdll_pkg::ST_RESP) begin
      out_ok_r <= ok_r;
      out_val_r <= val_r;
      out_pos_r <= pos_r;
      out_cnt_r <= cnt_r;
      out_empty_r <= (cnt_r == '0);
      out_full_r <= (cnt_r >= eff_cap);
    end
  end

  a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_valid_r) else $error("input ready while result pending");
  a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == 32'(cnt_r)) else $error("entry count differs from used slots");
  a_empty_no_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == NIL && tail_r == NIL)) else $error("empty list with head or tail");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NIL) else $error("entry count above pool depth");
endmodule
